>>> rtl/coap_opt_pkg.sv
// Types and constants shared by the CoAP option decoder.
// Transfer payload structs, parser phase and result kind codes.
// No dependencies.
package coap_opt_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_D1,
    PH_D2H,
    PH_D2L,
    PH_L1,
    PH_L2H,
    PH_L2L,
    PH_VAL
  } phase_t;

  // Result kind
  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_VAL   = 3'd1,
    KIND_OK    = 3'd2,
    KIND_NOOPT = 3'd3,
    KIND_WRONG = 3'd4,
    KIND_TRUNC = 3'd5
  } kind_t;

  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_EXT2       = 4'd14;
  localparam logic [3:0]  NIB_RSVD       = 4'd15;
  localparam logic [15:0] EXT1_BIAS      = 16'd13;
  localparam logic [15:0] EXT2_BIAS      = 16'd269;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } coap_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [7:0]  value_byte;
    logic [15:0] byte_offset;
    logic        done_res;
  } coap_out_t;

endpackage

>>> rtl/coap_option_decoder.sv
// Top level of the streaming CoAP option decoder.
// Input register, decode stage and result register.
// Depends on coap_opt_pkg and coap_opt_decode.
//
// Usage:
//  - in_valid/in_stall/in_data: one message byte per transfer, starting at the
//    first option byte. first_byte restarts the parser; last_byte marks the
//    final message byte.
//  - out_valid/out_stall/out_data: zero or one result per input byte: option
//    header, value byte, or one final status (done_res set) per message.
//  - A transfer happens on a rising edge with valid high and stall low.
//  - Throughput: one byte per cycle while out_stall is low. The decode is a single pass
//    of 16-bit add/compare logic between the input and result registers.
//  - Path: an accepted byte goes from the input register through decode into the
//    result register (out_valid high in the cycle after the byte leaves the input reg).
//  - Stall: while out_stall holds a waiting result, the decode stage halts;
//    the input register still takes one byte, then in_stall rises.
//  - Reset (rst_n low, synchronous): both registers empty, parser idle, and
//    the next byte is treated as a message start.
//  - Bytes after a status are dropped with no result until first_byte.
module coap_option_decoder #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  coap_opt_pkg::coap_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output coap_opt_pkg::coap_out_t out_data
);
  import coap_opt_pkg::*;

  logic      in_valid_r, in_valid_nxt;
  coap_in_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  coap_out_t out_data_r;

  logic      advance;
  logic      step;
  logic      res_valid;
  coap_out_t res;
  logic      dec_idle;

  // result register free, or its result leaves this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign step     = in_valid_r && advance;

  assign in_valid_nxt  = in_stall ? in_valid_r : in_valid;
  assign out_valid_nxt = advance ? (step && res_valid) : out_valid_r;

  coap_opt_decode #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (in_data_r),
    .res_valid(res_valid),
    .res      (res),
    .idle     (dec_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a status result leaves the parser idle
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.done_res |=> dec_idle)
    else $error("parser not idle after status result");

  // input stage only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stall without blocked result");

  // a held input byte is not lost or altered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("held input byte changed");

endmodule

>>> rtl/coap_opt_decode.sv
// Parser state and per-byte decode for the CoAP option decoder.
// Holds phase, option number, length and value count; one byte per step.
// Depends on coap_opt_pkg.
module coap_opt_decode #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  coap_opt_pkg::coap_in_t  item,
  output logic                  res_valid,
  output coap_opt_pkg::coap_out_t res,
  output logic                  idle
);
  import coap_opt_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic                    at_first_r, at_first_nxt;
  logic [15:0]             running_r, running_nxt;
  logic [15:0]             cur_num_r, cur_num_nxt;
  logic [15:0]             cur_len_r, cur_len_nxt;
  logic [15:0]             left_r, left_nxt;
  logic [3:0]              len_nib_r, len_nib_nxt;
  logic [7:0]              high_r, high_nxt;
  logic [OFFSET_WIDTH-1:0] cnt_r, cnt_nxt;

  kind_t       kind_c;
  logic        has_c;
  logic [7:0]  vb_c;

  logic        start;
  logic [7:0]  b;
  logic [3:0]  dn;
  logic [15:0] run_b;
  logic [3:0]  ln_use;
  logic        do_delta;
  logic        do_hdr;

  assign b     = item.in_byte;
  assign dn    = b[7:4];
  assign start = item.first_byte || at_first_r;
  assign run_b = start ? 16'd0 : running_r;
  assign idle  = (phase_r == PH_IDLE);

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    at_first_nxt = at_first_r;
    running_nxt  = running_r;
    cur_num_nxt  = cur_num_r;
    cur_len_nxt  = cur_len_r;
    left_nxt     = left_r;
    len_nib_nxt  = len_nib_r;
    high_nxt     = high_r;
    cnt_nxt      = cnt_r;
    kind_c       = KIND_HDR;
    has_c        = 1'b0;
    vb_c         = 8'd0;
    ln_use       = len_nib_r;
    do_delta     = 1'b0;
    do_hdr       = 1'b0;

    if (start || (phase_r != PH_IDLE)) begin
      if (start) begin
        at_first_nxt = 1'b0;
        running_nxt  = 16'd0;
        cur_num_nxt  = 16'd0;
        cur_len_nxt  = 16'd0;
        left_nxt     = 16'd0;
        len_nib_nxt  = 4'd0;
        high_nxt     = 8'd0;
        cnt_nxt      = OFFSET_WIDTH'(1);
        phase_nxt    = PH_HDR;
        ln_use       = 4'd0;
      end else begin
        cnt_nxt = cnt_r + OFFSET_WIDTH'(1);
      end

      if (start && (item.last_byte || b == PAYLOAD_MARKER)) begin
        has_c  = 1'b1;
        kind_c = KIND_NOOPT;
      end else begin
        case (start ? PH_HDR : phase_r)
          PH_HDR: begin
            if (b == PAYLOAD_MARKER) begin
              has_c  = 1'b1;
              kind_c = KIND_OK;
            end else if (dn == NIB_RSVD) begin
              has_c  = 1'b1;
              kind_c = KIND_WRONG;
            end else begin
              len_nib_nxt = b[3:0];
              ln_use      = b[3:0];
              if (dn == NIB_EXT1) begin
                phase_nxt = PH_D1;
              end else if (dn == NIB_EXT2) begin
                phase_nxt = PH_D2H;
              end else begin
                cur_num_nxt = run_b + {12'd0, dn};
                do_delta    = 1'b1;
              end
            end
          end
          PH_D1: begin
            cur_num_nxt = run_b + {8'd0, b} + EXT1_BIAS;
            do_delta    = 1'b1;
          end
          PH_D2H: begin
            high_nxt  = b;
            phase_nxt = PH_D2L;
          end
          PH_D2L: begin
            cur_num_nxt = run_b + {high_r, b} + EXT2_BIAS;
            do_delta    = 1'b1;
          end
          PH_L1: begin
            cur_len_nxt = {8'd0, b} + EXT1_BIAS;
            do_hdr      = 1'b1;
          end
          PH_L2H: begin
            high_nxt  = b;
            phase_nxt = PH_L2L;
          end
          PH_L2L: begin
            cur_len_nxt = {high_r, b} + EXT2_BIAS;
            do_hdr      = 1'b1;
          end
          PH_VAL: begin
            vb_c     = b;
            has_c    = 1'b1;
            kind_c   = KIND_VAL;
            left_nxt = left_r - 16'd1;
            if (left_nxt == 16'd0) begin
              phase_nxt = PH_HDR;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase

        // delta known: look at the length nibble
        if (do_delta) begin
          case (ln_use)
            NIB_EXT1: phase_nxt = PH_L1;
            NIB_EXT2: phase_nxt = PH_L2H;
            NIB_RSVD: begin
              has_c  = 1'b1;
              kind_c = KIND_WRONG;
            end
            default: begin
              cur_len_nxt = {12'd0, ln_use};
              do_hdr      = 1'b1;
            end
          endcase
        end

        // header complete: commit number, start value count
        if (do_hdr) begin
          running_nxt = cur_num_nxt;
          left_nxt    = cur_len_nxt;
          phase_nxt   = (cur_len_nxt == 16'd0) ? PH_HDR : PH_VAL;
          has_c       = 1'b1;
          kind_c      = KIND_HDR;
        end
      end

      // message ends early
      if (item.last_byte && (!has_c || kind_c == KIND_HDR || kind_c == KIND_VAL)) begin
        has_c  = 1'b1;
        kind_c = KIND_TRUNC;
      end

      if (has_c && kind_c != KIND_HDR && kind_c != KIND_VAL) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Result
  always_comb begin
    res_valid       = has_c;
    res.kind        = kind_c;
    res.byte_offset = 16'(cnt_nxt);
    if (kind_c == KIND_HDR || kind_c == KIND_VAL) begin
      res.option_number = cur_num_nxt;
      res.option_length = cur_len_nxt;
      res.value_byte    = vb_c;
      res.done_res      = 1'b0;
    end else begin
      res.option_number = 16'd0;
      res.option_length = 16'd0;
      res.value_byte    = 8'd0;
      res.done_res      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      at_first_r <= 1'b1;
      running_r  <= 16'd0;
      cur_num_r  <= 16'd0;
      cur_len_r  <= 16'd0;
      left_r     <= 16'd0;
      len_nib_r  <= 4'd0;
      high_r     <= 8'd0;
      cnt_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      at_first_r <= at_first_nxt;
      running_r  <= running_nxt;
      cur_num_r  <= cur_num_nxt;
      cur_len_r  <= cur_len_nxt;
      left_r     <= left_nxt;
      len_nib_r  <= len_nib_nxt;
      high_r     <= high_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
